FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);

	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int CHAR_W   = 8;
	localparam int COLOUR_W = 8;
	localparam int CELL_W   = 16;
	localparam int CMD_W    = 2;

	localparam logic [CELL_W-1:0]   BLANK_CELL      = 16'h0720;
	localparam logic [COLOUR_W-1:0] TEXT_COLOUR_RST = 8'h07;
	localparam logic [CHAR_W-1:0]   CH_NEWLINE      = 8'h0A;
	localparam logic [CHAR_W-1:0]   CH_RETURN       = 8'h0D;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW1_ADDR     = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_ROW_ADDR = ADDR_W'((ROWS - 1) * COLUMNS);

	typedef struct packed {
		logic accept;
		logic exec;
		logic copy_step;
		logic copy_drain;
		logic fill_step;
		logic out_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic ptr_last;
		logic scroll;
		logic is_clear;
		logic out_free;
	} tcw_stat_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

	function automatic logic cell_in_range(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		cell_in_range = (32'(row) < ROWS) && (32'(col) < COLUMNS);
	endfunction

endpackage

FILE: rtl/core/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/tcw_ctrl.sv
module tcw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcw_pkg::tcw_stat_t stat,
	output tcw_pkg::tcw_cmd_t  ctl
);

	localparam logic [2:0] ST_FILL  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_COPY  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       pend_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		ctl = '0;
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				ctl.fill_step = 1'b1;
				if (stat.ptr_last) begin
					state_d = pend_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				if (stat.is_clear) begin
					state_d = ST_FILL;
				end else if (stat.scroll) begin
					state_d = ST_COPY;
				end else if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_COPY: begin
				ctl.copy_step = 1'b1;
				if (stat.ptr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				ctl.copy_drain = 1'b1;
				state_d = ST_FILL;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.accept) begin
				pend_q <= 1'b1;
			end else if (ctl.out_load) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/tcw_dp.sv
module tcw_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcw_pkg::tcw_cmd_t              ctl,
	output tcw_pkg::tcw_stat_t             stat,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::COLOUR_W-1:0]   cfg_wdata,
	output logic [tcw_pkg::COLOUR_W-1:0]   text_colour,
	input  logic [tcw_pkg::CMD_W-1:0]      cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcw_pkg::ROW_W-1:0]      cell_row,
	input  logic [tcw_pkg::COL_W-1:0]      cell_col,
	input  logic [tcw_pkg::COLOUR_W-1:0]   cell_colour,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tcw_pkg::CELL_W-1:0]     read_data,
	output logic [tcw_pkg::ROW_W-1:0]      cursor_row_now,
	output logic [tcw_pkg::COL_W-1:0]      cursor_col_now,
	output logic                           did_scroll
);

	logic [tcw_pkg::COLOUR_W-1:0] colour_q;
	logic [tcw_pkg::CMD_W-1:0]    cmd_q;
	logic [tcw_pkg::CHAR_W-1:0]   ch_q;
	logic [tcw_pkg::COLOUR_W-1:0] cell_colour_q;
	logic [tcw_pkg::ADDR_W-1:0]   addr_q;
	logic                         rng_q;
	logic [tcw_pkg::ROW_W-1:0]    row_q;
	logic [tcw_pkg::COL_W-1:0]    col_q;
	logic                         scroll_q;
	logic [tcw_pkg::ADDR_W-1:0]   ptr_q;
	logic                         cp_valid_s1;
	logic [tcw_pkg::ADDR_W-1:0]   cp_addr_s1;
	logic                         out_valid_q;
	logic [tcw_pkg::CELL_W-1:0]   read_data_q;
	logic [tcw_pkg::ROW_W-1:0]    out_row_q;
	logic [tcw_pkg::COL_W-1:0]    out_col_q;
	logic                         out_scroll_q;

	logic                         printable;
	logic                         row_inc;
	logic                         scroll;
	logic [tcw_pkg::ROW_W-1:0]    row_nx;
	logic [tcw_pkg::COL_W-1:0]    col_nx;

	logic                         we;
	logic [tcw_pkg::ADDR_W-1:0]   waddr;
	logic [tcw_pkg::CELL_W-1:0]   wdata;
	logic                         re;
	logic [tcw_pkg::ADDR_W-1:0]   raddr;
	logic [tcw_pkg::CELL_W-1:0]   rdata;

	assign printable = (ch_q != tcw_pkg::CH_NEWLINE) && (ch_q != tcw_pkg::CH_RETURN);

	// cursor advance for a put
	always_comb begin
		row_inc = 1'b0;
		col_nx  = '0;
		if (ch_q == tcw_pkg::CH_NEWLINE) begin
			row_inc = 1'b1;
		end else if (printable) begin
			if (32'(col_q) == tcw_pkg::COLUMNS - 1) begin
				row_inc = 1'b1;
			end else begin
				col_nx = col_q + 1'b1;
			end
		end
		scroll = row_inc && (32'(row_q) == tcw_pkg::ROWS - 1);
		if (row_inc && !scroll) begin
			row_nx = row_q + 1'b1;
		end else begin
			row_nx = row_q;
		end
	end

	// memory ports
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = tcw_pkg::BLANK_CELL;
		if (ctl.fill_step) begin
			we = 1'b1;
		end
		if ((ctl.copy_step || ctl.copy_drain) && cp_valid_s1) begin
			we    = 1'b1;
			waddr = cp_addr_s1;
			wdata = rdata;
		end
		if (ctl.exec) begin
			if (cmd_q == tcw_pkg::CMD_PUT && printable) begin
				we    = 1'b1;
				waddr = tcw_pkg::cell_addr(row_q, col_q);
				wdata = {colour_q, ch_q};
			end else if (cmd_q == tcw_pkg::CMD_SET && rng_q) begin
				we    = 1'b1;
				waddr = addr_q;
				wdata = {cell_colour_q, ch_q};
			end
		end
		re    = ctl.accept || ctl.copy_step;
		raddr = ctl.copy_step ? ptr_q : tcw_pkg::cell_addr(cell_row, cell_col);
	end

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(tcw_pkg::CELLS)
	) u_screen (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q         <= cmd;
			ch_q          <= char_code;
			cell_colour_q <= cell_colour;
			addr_q        <= tcw_pkg::cell_addr(cell_row, cell_col);
			rng_q         <= tcw_pkg::cell_in_range(cell_row, cell_col);
		end
		if (ctl.exec) begin
			scroll_q <= (cmd_q == tcw_pkg::CMD_PUT) && scroll;
		end
		cp_addr_s1 <= ptr_q - tcw_pkg::ROW1_ADDR;
		if (ctl.out_load) begin
			read_data_q  <= (cmd_q == tcw_pkg::CMD_READ && rng_q) ? rdata : '0;
			// loaded in the execute cycle the cursor has not moved yet
			out_row_q    <= (ctl.exec && cmd_q == tcw_pkg::CMD_PUT) ? row_nx : row_q;
			out_col_q    <= (ctl.exec && cmd_q == tcw_pkg::CMD_PUT) ? col_nx : col_q;
			out_scroll_q <= ctl.exec ? ((cmd_q == tcw_pkg::CMD_PUT) && scroll) : scroll_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q    <= tcw_pkg::TEXT_COLOUR_RST;
			row_q       <= '0;
			col_q       <= '0;
			ptr_q       <= '0;
			cp_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				colour_q <= cfg_wdata;
			end
			if (ctl.exec) begin
				if (cmd_q == tcw_pkg::CMD_PUT) begin
					row_q <= row_nx;
					col_q <= col_nx;
				end else if (cmd_q == tcw_pkg::CMD_CLEAR) begin
					row_q <= '0;
					col_q <= '0;
				end
			end
			if (ctl.exec) begin
				ptr_q <= (cmd_q == tcw_pkg::CMD_CLEAR) ? '0 : tcw_pkg::ROW1_ADDR;
			end else if (ctl.copy_step) begin
				ptr_q <= (ptr_q == tcw_pkg::LAST_ADDR) ? tcw_pkg::LAST_ROW_ADDR
					: ptr_q + 1'b1;
			end else if (ctl.fill_step) begin
				ptr_q <= ptr_q + 1'b1;
			end
			cp_valid_s1 <= ctl.copy_step;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.ptr_last = (ptr_q == tcw_pkg::LAST_ADDR);
	assign stat.scroll   = (cmd_q == tcw_pkg::CMD_PUT) && scroll;
	assign stat.is_clear = (cmd_q == tcw_pkg::CMD_CLEAR);
	assign stat.out_free = !out_valid_q || out_ready;

	assign text_colour    = colour_q;
	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign cursor_row_now = out_row_q;
	assign cursor_col_now = out_col_q;
	assign did_scroll     = out_scroll_q;

endmodule

FILE: rtl/core/text_console_writer.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------------
// cfg      | psel penable pwrite  | paddr pwdata prdata (text_colour at 0), pready = 1
// in       | in_valid in_ready    | cmd char_code cell_row cell_col cell_colour
// out      | out_valid out_ready  | read_data cursor_row_now cursor_col_now did_scroll
//
// Put, set and read pass through the accept and execute states, since the screen RAM
// read is registered. A scrolling put copies the rows up through the RAM, one cell per
// cycle, then blanks the bottom row; clear blanks all ROWS*COLUMNS cells.
// After reset a clearing pass blanks all ROWS*COLUMNS (2000) cells before in_ready rises.
// A stalled output holds its result; the next input is taken while it waits.
module text_console_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tcw_pkg::CMD_W-1:0]      cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcw_pkg::ROW_W-1:0]      cell_row,
	input  logic [tcw_pkg::COL_W-1:0]      cell_col,
	input  logic [tcw_pkg::COLOUR_W-1:0]   cell_colour,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tcw_pkg::CELL_W-1:0]     read_data,
	output logic [tcw_pkg::ROW_W-1:0]      cursor_row_now,
	output logic [tcw_pkg::COL_W-1:0]      cursor_col_now,
	output logic                           did_scroll
);

	tcw_pkg::tcw_cmd_t            ctl;
	tcw_pkg::tcw_stat_t           stat;
	logic                         cfg_we;
	logic [tcw_pkg::COLOUR_W-1:0] text_colour;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : 32'(text_colour);

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	tcw_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_wdata      (pwdata[tcw_pkg::COLOUR_W-1:0]),
		.text_colour    (text_colour),
		.cmd            (cmd),
		.char_code      (char_code),
		.cell_row       (cell_row),
		.cell_col       (cell_col),
		.cell_colour    (cell_colour),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_data      (read_data),
		.cursor_row_now (cursor_row_now),
		.cursor_col_now (cursor_col_now),
		.did_scroll     (did_scroll)
	);

endmodule
